// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands for the checker modules of this project.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCDG_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCDG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/vcdg_pkg.sv -----
package vcdg_pkg;

	// Width of every gradient component, signed Q15.0.
	localparam int GRAD_W = 16;

	// Size registers and their reset value.
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

	// Width used to compare a size register against the largest axis span.
	localparam int SIZE_CMP_W = 11;

	// Register indices on the configuration channel.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// Command codes of an input word.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

endpackage

// ----- hw/rtl/vcdg_if.sv -----
// Input channel: voxel writes and gradient queries.
interface vcdg_item_if #(
	parameter int X_BITS = 6,
	parameter int Y_BITS = 6,
	parameter int Z_BITS = 6,
	parameter int VOXEL_BITS = 16
);
	logic valid;
	logic ready;
	logic command;
	logic [X_BITS-1:0] pos_x;
	logic [Y_BITS-1:0] pos_y;
	logic [Z_BITS-1:0] pos_z;
	logic [VOXEL_BITS-1:0] density;

	modport source (output valid, command, pos_x, pos_y, pos_z, density, input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, density, output ready);
endinterface

// Result channel: one gradient word per query.
interface vcdg_result_if;
	logic valid;
	logic ready;
	logic signed [vcdg_pkg::GRAD_W-1:0] grad_x;
	logic signed [vcdg_pkg::GRAD_W-1:0] grad_y;
	logic signed [vcdg_pkg::GRAD_W-1:0] grad_z;

	modport source (output valid, grad_x, grad_y, grad_z, input ready);
	modport sink (input valid, grad_x, grad_y, grad_z, output ready);
endinterface

// Configuration write channel.
interface vcdg_cfg_if;
	logic valid;
	logic ready;
	logic [vcdg_pkg::CFG_IDX_W-1:0] index;
	logic [vcdg_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/volume_central_difference_gradient_core.sv -----
// Central-difference gradient over a voxel volume held in one single-port memory.
// The item channel carries a command, a coordinate and a density. A write word stores
// the density at {z,y,x}; the block stays ready for the next word.
// A query word returns floor((v(+1) - v(-1)) / 2) along each axis, with the queried
// coordinate and its neighbours clamped to the volume set by size_x, size_y, size_z.
// A query reads the six neighbours through the one memory port, each read registered,
// into one shared subtractor; the S_DONE state then hands the result word to the output
// register. The result appears in the same cycle as the item channel is ready again.
// A finished result waits in the output register; write words are still accepted then,
// and a later query completes its reads and holds in its last step until the
// output register is free.
// The configuration channel is always ready; registers 0..2 set the sizes, other
// indices are ignored. Reset sets all sizes to 64 and empties the output register.
// Voxel contents are not cleared by reset and must be written before being queried.
module volume_central_difference_gradient_core #(
	parameter int X_BITS = 6,
	parameter int Y_BITS = 6,
	parameter int Z_BITS = 6,
	parameter int VOXEL_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	vcdg_item_if.sink item,
	vcdg_result_if.source result,
	vcdg_cfg_if.sink cfg
);

	localparam int ADDR_W = X_BITS + Y_BITS + Z_BITS;
	localparam int DEPTH = 1 << ADDR_W;
	localparam int GW = vcdg_pkg::GRAD_W;
	localparam int CW = vcdg_pkg::SIZE_CMP_W;
	localparam int DIFF_W = (VOXEL_BITS + 1 > GW + 1) ? VOXEL_BITS + 1 : GW + 1;
	localparam logic [CW-1:0] X_TOP = CW'(1) << X_BITS;
	localparam logic [CW-1:0] Y_TOP = CW'(1) << Y_BITS;
	localparam logic [CW-1:0] Z_TOP = CW'(1) << Z_BITS;
	localparam logic [2:0] LAST_STEP = 3'd6;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic [vcdg_pkg::CFG_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [X_BITS-1:0] x_lim, x_q, xl, xh;
	logic [Y_BITS-1:0] y_lim, y_q, yl, yh;
	logic [Z_BITS-1:0] z_lim, z_q, zl, zh;
	logic [VOXEL_BITS-1:0] mem_q [DEPTH];
	logic [VOXEL_BITS-1:0] rdata_q, hi_q;
	logic [ADDR_W-1:0] mem_addr, rd_addr;
	logic mem_we;
	logic [DIFF_W-1:0] diff;
	logic [GW-1:0] half;
	logic [GW-1:0] gx_q, gy_q, gz_q;
	logic out_valid_q;
	logic [GW-1:0] out_gx_q, out_gy_q, out_gz_q;
	logic item_fire, out_free;

	assign cfg.ready = 1'b1;
	assign item.ready = (state_q == S_IDLE);
	assign item_fire = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.grad_x = out_gx_q;
	assign result.grad_y = out_gy_q;
	assign result.grad_z = out_gz_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= vcdg_pkg::SIZE_RESET;
			size_y_q <= vcdg_pkg::SIZE_RESET;
			size_z_q <= vcdg_pkg::SIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				vcdg_pkg::REG_SIZE_X: size_x_q <= cfg.data;
				vcdg_pkg::REG_SIZE_Y: size_y_q <= cfg.data;
				vcdg_pkg::REG_SIZE_Z: size_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Highest usable coordinate per axis: a size of zero acts as one, a size beyond
	// the axis span acts as the full span.
	always_comb begin
		if (size_x_q == '0) x_lim = '0;
		else if (CW'(size_x_q) > X_TOP) x_lim = X_BITS'(X_TOP - CW'(1));
		else x_lim = X_BITS'(CW'(size_x_q) - CW'(1));
		if (size_y_q == '0) y_lim = '0;
		else if (CW'(size_y_q) > Y_TOP) y_lim = Y_BITS'(Y_TOP - CW'(1));
		else y_lim = Y_BITS'(CW'(size_y_q) - CW'(1));
		if (size_z_q == '0) z_lim = '0;
		else if (CW'(size_z_q) > Z_TOP) z_lim = Z_BITS'(Z_TOP - CW'(1));
		else z_lim = Z_BITS'(CW'(size_z_q) - CW'(1));
	end

	// Neighbour coordinates of the clamped query point.
	assign xl = (x_q == '0) ? x_q : x_q - X_BITS'(1);
	assign xh = (x_q == x_lim) ? x_q : x_q + X_BITS'(1);
	assign yl = (y_q == '0) ? y_q : y_q - Y_BITS'(1);
	assign yh = (y_q == y_lim) ? y_q : y_q + Y_BITS'(1);
	assign zl = (z_q == '0) ? z_q : z_q - Z_BITS'(1);
	assign zh = (z_q == z_lim) ? z_q : z_q + Z_BITS'(1);

	// Read address for each step: upper then lower neighbour, axis by axis.
	always_comb begin
		case (step_q)
			3'd0: rd_addr = {z_q, y_q, xh};
			3'd1: rd_addr = {z_q, y_q, xl};
			3'd2: rd_addr = {z_q, yh, x_q};
			3'd3: rd_addr = {z_q, yl, x_q};
			3'd4: rd_addr = {zh, y_q, x_q};
			default: rd_addr = {zl, y_q, x_q};
		endcase
	end

	// The single memory port writes while idle and reads while a query runs.
	assign mem_we = item_fire && (item.command == vcdg_pkg::CMD_WRITE);
	assign mem_addr = (state_q == S_IDLE) ? {item.pos_z, item.pos_y, item.pos_x} : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= item.density;
		end
		rdata_q <= mem_q[mem_addr];
	end

	// Shared subtractor: halving is the arithmetic shift, taken as a bit slice.
	assign diff = DIFF_W'(hi_q) - DIFF_W'(rdata_q);
	assign half = diff[GW:1];

	// Sequencer, working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			hi_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= '0;
			out_valid_q <= 1'b0;
			out_gx_q <= '0;
			out_gy_q <= '0;
			out_gz_q <= '0;
		end else begin
			// The output register empties when its word is taken and no new word moves in.
			if (out_valid_q && result.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_fire && item.command == vcdg_pkg::CMD_QUERY) begin
						x_q <= (item.pos_x > x_lim) ? x_lim : item.pos_x;
						y_q <= (item.pos_y > y_lim) ? y_lim : item.pos_y;
						z_q <= (item.pos_z > z_lim) ? z_lim : item.pos_z;
						step_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					// Odd steps latch the upper neighbour, even steps after step 0 close a component.
					case (step_q)
						3'd2: gx_q <= half;
						3'd4: gy_q <= half;
						3'd6: gz_q <= half;
						3'd0: ;
						default: hi_q <= rdata_q;
					endcase
					if (step_q == LAST_STEP) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_gx_q <= gx_q;
						out_gy_q <= gy_q;
						out_gz_q <= gz_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/vcdg_checker.sv -----
`include "assert_macros.svh"

module vcdg_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_command,
	input logic out_valid,
	input logic out_ready,
	input logic [vcdg_pkg::GRAD_W-1:0] grad_x,
	input logic [vcdg_pkg::GRAD_W-1:0] grad_y,
	input logic [vcdg_pkg::GRAD_W-1:0] grad_z
);

	// A result word waits unchanged until it is taken.
	`VCDG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(grad_x) && $stable(grad_y) && $stable(grad_z), "result word dropped or changed while stalled")

	// A query occupies the block, so the item channel closes behind it.
	`VCDG_ASSERT_NEXT(a_query_busy, item_valid && item_ready && item_command == vcdg_pkg::CMD_QUERY, !item_ready, "item channel open during a query")

	// A voxel write leaves the item channel ready for the next word.
	`VCDG_ASSERT_NEXT(a_write_fast, item_valid && item_ready && item_command == vcdg_pkg::CMD_WRITE, item_ready, "voxel write stalled the item channel")

	// A new result only follows a busy period of a query.
	`VCDG_ASSERT_IMPL(a_result_source, $rose(out_valid), !$past(item_ready), "result word appeared without a running query")

endmodule

bind volume_central_difference_gradient_core vcdg_checker u_vcdg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.item_command(item.command),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.grad_x(result.grad_x),
	.grad_y(result.grad_y),
	.grad_z(result.grad_z)
);
